// ===== sv/sacl_pkg.sv =====
`timescale 1ns / 1ps

package sacl_pkg;

	// Fixed field widths of the ports.
	localparam int ADDR_IN_W = 32;
	localparam int WAY_OUT_W = 2;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	// Configuration register widths.
	localparam int AB_W = 6;
	localparam int SB_W = 3;
	localparam int WB_W = 2;
	localparam int BB_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAY_BITS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [AB_W-1:0] RST_ADDRESS_BITS = 6'd16;
	localparam logic [SB_W-1:0] RST_SET_BITS     = 3'd2;
	localparam logic [WB_W-1:0] RST_WAY_BITS     = 2'd0;
	localparam logic [BB_W-1:0] RST_BLOCK_BITS   = 4'd1;

endpackage

// ===== sv/set_associative_cache_lookup.sv =====
`timescale 1ns / 1ps

// Channel  | Signals                                         | Handshake
// ---------+-------------------------------------------------+----------------------------
// access   | start, address                                  | beat when start && !busy
// result   | done, hit, way_used, evicted, hits_so_far,      | beat on each cycle done is
//          | misses_so_far                                   | high, cannot be held off
// config   | cfg_we, cfg_index, cfg_wdata                    | write when cfg_we is high
//
// One access beat is taken every cycle; busy never rises. A result is registered
// after its beat passes the lookup stage: the set is read from the tag/rank memory
// and the valid flops at the access edge, then compared, updated and written back in
// one stage. A set written by the previous beat is forwarded from the update logic.
// Reset clears all valid bits, both counters and restores the configuration.

module set_associative_cache_lookup
	import sacl_pkg::*;
#(
	parameter int ADDR_WIDTH   = 32,
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAY_BITS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ADDR_IN_W-1:0] address,
	output logic                 done,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way_used,
	output logic                 evicted,
	output logic [CNT_W-1:0]     hits_so_far,
	output logic [CNT_W-1:0]     misses_so_far,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int AW    = ADDR_WIDTH;
	localparam int NSETS = 1 << MAX_SET_BITS;
	localparam int NWAYS = 1 << MAX_WAY_BITS;
	localparam int SETW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAYW  = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;
	localparam int NWW   = MAX_WAY_BITS + 1;

	typedef struct packed {
		logic [AW-1:0]   tag;
		logic [WAYW-1:0] rank;
	} way_ent_t;

	typedef way_ent_t [NWAYS-1:0] set_ent_t;

	// Configuration registers.
	logic [AB_W-1:0] address_bits_q;
	logic [SB_W-1:0] set_bits_q;
	logic [WB_W-1:0] way_bits_q;
	logic [BB_W-1:0] block_bits_q;

	// Storage.
	set_ent_t         line_mem [NSETS];
	logic [NWAYS-1:0] valid_q  [NSETS];

	// Lookup stage.
	logic             v_s1;
	logic             fwd_s1;
	logic [SETW-1:0]  set_s1;
	logic [AW-1:0]    tag_s1;
	set_ent_t         rd_s1;
	logic [NWAYS-1:0] vrd_s1;
	set_ent_t         fwd_set_q;
	logic [NWAYS-1:0] fwd_valid_q;

	// Result registers.
	logic                 done_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic                 evict_q;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     miss_cnt_q;

	logic             accept;
	logic [SB_W-1:0]  sb_c;
	logic [WB_W-1:0]  wb_c;
	logic [AW-1:0]    amask_c;
	logic [AW-1:0]    shifted_c;
	logic [SETW-1:0]  setmask_c;
	logic [SETW-1:0]  set_in_c;
	logic [AW-1:0]    tag_in_c;

	logic [NWW-1:0]   nways_c;
	logic [NWAYS-1:0] act_c;
	set_ent_t         cur_c;
	logic [NWAYS-1:0] curv_c;
	logic             hit_c;
	logic [WAYW-1:0]  hit_way_c;
	logic             free_c;
	logic [WAYW-1:0]  free_way_c;
	logic [WAYW-1:0]  lru_way_c;
	logic [WAYW-1:0]  lru_rank_c;
	logic [WAYW-1:0]  way_c;
	logic [WAYW-1:0]  old_rank_c;
	logic             evict_c;
	set_ent_t         new_set_c;
	logic [NWAYS-1:0] new_valid_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Geometry clamped to what the storage holds.
	assign sb_c = (int'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits_q;
	assign wb_c = (int'(way_bits_q) > MAX_WAY_BITS) ? WB_W'(MAX_WAY_BITS) : way_bits_q;

	// Split the incoming address into set and tag.
	always_comb begin
		for (int i = 0; i < AW; i++) begin
			amask_c[i] = (i < int'(address_bits_q));
		end
		for (int i = 0; i < SETW; i++) begin
			setmask_c[i] = (i < int'(sb_c));
		end
		shifted_c = (AW'(address) & amask_c) >> block_bits_q;
		set_in_c  = shifted_c[SETW-1:0] & setmask_c;
		tag_in_c  = shifted_c >> sb_c;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_bits_q <= RST_ADDRESS_BITS;
			set_bits_q     <= RST_SET_BITS;
			way_bits_q     <= RST_WAY_BITS;
			block_bits_q   <= RST_BLOCK_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ADDRESS_BITS: address_bits_q <= cfg_wdata[AB_W-1:0];
				REG_SET_BITS:     set_bits_q     <= cfg_wdata[SB_W-1:0];
				REG_WAY_BITS:     way_bits_q     <= cfg_wdata[WB_W-1:0];
				REG_BLOCK_BITS:   block_bits_q   <= cfg_wdata[BB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Set state seen by the lookup stage, with the previous beat's update forwarded.
	assign cur_c  = fwd_s1 ? fwd_set_q : rd_s1;
	assign curv_c = fwd_s1 ? fwd_valid_q : vrd_s1;

	always_comb begin
		nways_c = NWW'(1) << wb_c;
		for (int w = 0; w < NWAYS; w++) begin
			act_c[w] = (NWW'(w) < nways_c);
		end

		// Lowest matching valid way, and lowest invalid way.
		hit_c      = 1'b0;
		hit_way_c  = '0;
		free_c     = 1'b0;
		free_way_c = '0;
		for (int w = NWAYS - 1; w >= 0; w--) begin
			if (act_c[w] && curv_c[w] && (cur_c[w].tag == tag_s1)) begin
				hit_c     = 1'b1;
				hit_way_c = WAYW'(w);
			end
			if (act_c[w] && !curv_c[w]) begin
				free_c     = 1'b1;
				free_way_c = WAYW'(w);
			end
		end

		// Oldest way; a tie goes to the lowest way.
		lru_way_c  = '0;
		lru_rank_c = cur_c[0].rank;
		for (int w = 1; w < NWAYS; w++) begin
			if (act_c[w] && (cur_c[w].rank > lru_rank_c)) begin
				lru_way_c  = WAYW'(w);
				lru_rank_c = cur_c[w].rank;
			end
		end

		evict_c = !hit_c && !free_c;
		if (hit_c) begin
			way_c      = hit_way_c;
			old_rank_c = cur_c[hit_way_c].rank;
		end else begin
			way_c      = free_c ? free_way_c : lru_way_c;
			// A filled way counts as the oldest before it is made most recent.
			old_rank_c = WAYW'(nways_c - NWW'(1));
		end

		new_set_c   = cur_c;
		new_valid_c = curv_c;
		for (int v = 0; v < NWAYS; v++) begin
			if (act_c[v] && (WAYW'(v) != way_c) && curv_c[v]
					&& (cur_c[v].rank < old_rank_c)) begin
				new_set_c[v].rank = cur_c[v].rank + WAYW'(1);
			end
		end
		new_set_c[way_c].rank = '0;
		if (!hit_c) begin
			new_set_c[way_c].tag = tag_s1;
			new_valid_c[way_c]   = 1'b1;
		end
	end

	// Tag and rank memory: one set per entry, all ways side by side.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[set_s1] <= new_set_c;
		end
		if (accept) begin
			rd_s1 <= line_mem[set_in_c];
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_in_c;
			tag_s1 <= tag_in_c;
			vrd_s1 <= valid_q[set_in_c];
		end
		if (v_s1) begin
			fwd_set_q   <= new_set_c;
			fwd_valid_q <= new_valid_c;
			hit_q       <= hit_c;
			way_q       <= WAY_OUT_W'(way_c);
			evict_q     <= evict_c;
		end
	end

	// Valid bits, stage control and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NSETS; s++) begin
				valid_q[s] <= '0;
			end
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
			done_q     <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			v_s1   <= accept;
			fwd_s1 <= accept && v_s1 && (set_s1 == set_in_c);
			done_q <= v_s1;
			if (v_s1) begin
				valid_q[set_s1] <= new_valid_c;
				if (hit_c) begin
					if (hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + CNT_W'(1);
					end
				end else begin
					if (miss_cnt_q != '1) begin
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
					end
				end
			end
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign way_used      = way_q;
	assign evicted       = evict_q;
	assign hits_so_far   = hit_cnt_q;
	assign misses_so_far = miss_cnt_q;

endmodule
